@@ sv/cpts_pkg.sv @@
// Shared types, widths and codes for the counter/priority task scheduler.
package cpts_pkg;

  localparam int NUM_TASKS = 16;
  localparam int PRIO_BITS = 8;
  localparam int IDX_W     = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // Fixed port field widths.
  localparam int FUNC_W    = 1;
  localparam int SLOT_W    = 4;
  localparam int IN_PRIO_W = 8;
  localparam int CNT_W     = 9;
  localparam int STATUS_W  = 3;
  localparam int TASK_W    = 4;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int SUM_W = ((PRIO_BITS > CNT_W) ? PRIO_BITS : CNT_W) + 1;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DOWN    = 3'd0,
    ST_KEPT    = 3'd1,
    ST_SWITCH  = 3'd2,
    ST_NONE    = 3'd3,
    ST_ZERO    = 3'd4,
    ST_WRITTEN = 3'd5
  } status_t;

  // One task slot as it travels along the ring.
  typedef struct packed {
    logic                 present;
    logic                 runnable;
    logic [PRIO_BITS-1:0] prio;
    logic [CNT_W-1:0]     cnt;
  } task_ent_t;

  typedef struct packed {
    logic              clear;
    logic              active;
    logic              wr_en;
    logic              dec_en;
    logic              refill;
    logic [IDX_W-1:0]  idx;
    logic [IDX_W-1:0]  cur;
    logic [SLOT_W-1:0] wr_slot;
    task_ent_t         wr_ent;
  } scan_ctl_t;

  typedef struct packed {
    logic             found;
    logic             dec_hit;
    logic [CNT_W-1:0] best;
    logic [IDX_W-1:0] sel;
    logic [CNT_W-1:0] cap;
  } scan_res_t;

endpackage

@@ sv/cpts_if.sv @@
// Valid/ready channel interfaces for scheduler items and results.
interface cpts_in_if
  import cpts_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [SLOT_W-1:0]    slot;
  logic                 present;
  logic                 runnable;
  logic [IN_PRIO_W-1:0] prio;
  logic [CNT_W-1:0]     slice;

  modport source (output valid, func, slot, present, runnable, prio, slice, input ready);
  modport sink   (input valid, func, slot, present, runnable, prio, slice, output ready);
endinterface

interface cpts_out_if
  import cpts_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TASK_W-1:0]   running_task;
  logic [CNT_W-1:0]    running_counter;

  modport source (output valid, status, running_task, running_counter, input ready);
  modport sink   (input valid, status, running_task, running_counter, output ready);
endinterface

@@ sv/counter_priority_task_scheduler_unit.sv @@
// Top level of the counter/priority task scheduler: ring of slot cells plus sequencer.
//
// Usage
//   in_ch  : one word per item. func selects a timer tick or a slot write
//            (slot, present, runnable, prio, slice).
//   out_ch : one word per item: status, running_task, running_counter.
//   Both channels move a word when valid and ready are high at a clock edge.
// Structure
//   The task table lives in a ring of NUM_TASKS cells. For every item the ring
//   turns once, one cell per cycle; the unit at cell 0 applies the write, the
//   countdown or the refill to the slot passing by and tracks the best pick.
// Sequence
//   Each item is taken in idle and passes the ring; its result is registered
//   before the next word is taken. A tick that finds every eligible counter
//   at zero turns the ring again for refill and repick.
// Reset: synchronous, active low: all slots empty, zero fields, current task 0.
// Backpressure: a stalled receiver keeps the result in the output register; the
//   next word is still taken and worked, then waits at the check with in_ch.ready low.
module counter_priority_task_scheduler_unit
  import cpts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  cpts_in_if.sink    in_ch,
  cpts_out_if.source out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_CHECK
  } state_t;

  state_t            state_r, state_nxt;
  logic              pass2_r, pass2_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [FUNC_W-1:0] func_r, func_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  task_ent_t         wr_ent_r, wr_ent_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  status_t           status_r, status_nxt;
  logic [TASK_W-1:0] task_r, task_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              in_acc;
  logic              out_free;
  logic              last;
  scan_ctl_t         ctl;
  scan_res_t         res;
  task_ent_t         ring [NUM_TASKS];
  task_ent_t         tail;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign last     = (idx_r == IDX_W'(NUM_TASKS - 1));

  // ring: cell k takes from cell k+1, the last cell from the head unit
  for (genvar k = 0; k < NUM_TASKS; k++) begin : g_cell
    task_ent_t nb;
    if (k == NUM_TASKS - 1) begin : g_tail
      assign nb = tail;
    end else begin : g_mid
      assign nb = ring[k+1];
    end
    cpts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (state_r == S_PASS),
      .ent_i    (nb),
      .ent_o    (ring[k])
    );
  end

  cpts_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .head_i (ring[0]),
    .tail_o (tail),
    .res_o  (res)
  );

  always_comb begin
    state_nxt     = state_r;
    pass2_nxt     = pass2_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    func_nxt      = func_r;
    slot_nxt      = slot_r;
    wr_ent_nxt    = wr_ent_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    task_nxt      = task_r;
    cnt_nxt       = cnt_r;

    ctl.clear   = 1'b0;
    ctl.active  = (state_r == S_PASS);
    ctl.wr_en   = (func_r == FUNC_WRITE) && !pass2_r;
    ctl.dec_en  = (func_r == FUNC_TICK) && !pass2_r;
    ctl.refill  = pass2_r;
    ctl.idx     = idx_r;
    ctl.cur     = cur_r;
    ctl.wr_slot = slot_r;
    ctl.wr_ent  = wr_ent_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ctl.clear  = 1'b1;
          func_nxt   = in_ch.func;
          slot_nxt   = in_ch.slot;
          wr_ent_nxt = '{present: in_ch.present, runnable: in_ch.runnable,
                         prio: PRIO_BITS'(in_ch.prio), cnt: in_ch.slice};
          pass2_nxt  = 1'b0;
          idx_nxt    = '0;
          state_nxt  = S_PASS;
        end
      end
      S_PASS: begin
        if (last) begin
          idx_nxt   = '0;
          state_nxt = S_CHECK;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_CHECK: begin
        if (!pass2_r && (func_r == FUNC_TICK) && !res.dec_hit && res.found &&
            (res.best == '0)) begin
          // every eligible counter is spent: refill and pick again
          ctl.clear = 1'b1;
          pass2_nxt = 1'b1;
          state_nxt = S_PASS;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          cnt_nxt       = res.cap;
          if (func_r == FUNC_WRITE) begin
            status_nxt = ST_WRITTEN;
          end else if (res.dec_hit) begin
            status_nxt = ST_DOWN;
          end else if (!res.found) begin
            status_nxt = pass2_r ? ST_ZERO : ST_NONE;
          end else if (res.best == '0) begin
            status_nxt = ST_ZERO;
          end else begin
            status_nxt = (res.sel == cur_r) ? ST_KEPT : ST_SWITCH;
            cur_nxt    = res.sel;
            cnt_nxt    = res.best;
          end
          task_nxt = TASK_W'(cur_nxt);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass2_r     <= 1'b0;
      idx_r       <= '0;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass2_r     <= pass2_nxt;
      idx_r       <= idx_nxt;
      cur_r       <= cur_nxt;
      out_valid_r <= out_valid_nxt;
    end
    func_r   <= func_nxt;
    slot_r   <= slot_nxt;
    wr_ent_r <= wr_ent_nxt;
    status_r <= status_nxt;
    task_r   <= task_nxt;
    cnt_r    <= cnt_nxt;
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = status_r;
  assign out_ch.running_task    = task_r;
  assign out_ch.running_counter = cnt_r;

  // ring must be back at its home position whenever no item is in work
  a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (idx_r == '0))
    else $error("ring index not home while idle");

  // a pick only lands on a task with time left
  a_pick_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((status_r == ST_KEPT) || (status_r == ST_SWITCH))) |->
      (cnt_r != '0))
    else $error("picked task has zero counter");

  // the idle task is never picked
  a_pick_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ((status_r == ST_KEPT) || (status_r == ST_SWITCH))) |->
      (task_r != '0))
    else $error("idle slot picked");

  // a countdown result never shows a full counter
  a_down_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && state_nxt == S_IDLE && status_nxt == ST_DOWN) |=>
      (cnt_r != CNT_MAX))
    else $error("countdown result at maximum");

endmodule

@@ sv/cpts_cell.sv @@
// One ring cell: holds a task slot and passes it to its neighbor on a shift.
module cpts_cell
  import cpts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      shift_en,
  input  task_ent_t ent_i,
  output task_ent_t ent_o
);

  task_ent_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else if (shift_en) begin
      ent_r <= ent_i;
    end
  end

  assign ent_o = ent_r;

endmodule

@@ sv/cpts_scan.sv @@
// Ring head unit: updates the slot leaving cell 0 and tracks the best pick.
module cpts_scan
  import cpts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  scan_ctl_t ctl,
  input  task_ent_t head_i,
  output task_ent_t tail_o,
  output scan_res_t res_o
);

  logic             found_r, found_nxt;
  logic             dec_r, dec_nxt;
  logic [CNT_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0] sel_r, sel_nxt;
  logic [CNT_W-1:0] cap_r, cap_nxt;

  task_ent_t        mod;
  logic [SUM_W-1:0] sum;
  logic             not_idle;
  logic             is_cur;
  logic             eligible;

  always_comb begin
    not_idle  = (ctl.idx != '0);
    is_cur    = (ctl.idx == ctl.cur);
    sum       = SUM_W'(head_i.cnt >> 1) + SUM_W'(head_i.prio);
    mod       = head_i;
    found_nxt = found_r;
    dec_nxt   = dec_r;
    best_nxt  = best_r;
    sel_nxt   = sel_r;
    cap_nxt   = cap_r;

    if (ctl.wr_en && not_idle && (32'(ctl.idx) == 32'(ctl.wr_slot))) begin
      mod = ctl.wr_ent;
    end
    // refill: halve and add priority, saturating
    if (ctl.refill && not_idle && head_i.present) begin
      mod.cnt = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : CNT_W'(sum);
    end
    if (ctl.dec_en && is_cur && not_idle && (head_i.cnt != '0)) begin
      mod.cnt = head_i.cnt - CNT_W'(1);
      dec_nxt = 1'b1;
    end

    eligible = not_idle && mod.present && mod.runnable;

    if (ctl.clear) begin
      found_nxt = 1'b0;
      dec_nxt   = 1'b0;
      best_nxt  = '0;
      sel_nxt   = '0;
    end else if (ctl.active) begin
      // ascending scan, >= lets the highest slot win a tie
      if (eligible && (!found_r || (mod.cnt >= best_r))) begin
        found_nxt = 1'b1;
        best_nxt  = mod.cnt;
        sel_nxt   = ctl.idx;
      end
      if (is_cur) begin
        cap_nxt = mod.cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      dec_r   <= 1'b0;
    end else begin
      found_r <= found_nxt;
      dec_r   <= dec_nxt;
    end
    best_r <= best_nxt;
    sel_r  <= sel_nxt;
    cap_r  <= cap_nxt;
  end

  assign tail_o = mod;
  assign res_o  = '{found: found_r, dec_hit: dec_r, best: best_r, sel: sel_r, cap: cap_r};

endmodule

@@ test/counter_priority_task_scheduler_unit_test.sv @@
`timescale 1ns / 1ps
// Self-checking test of the counter/priority task scheduler: directed cases, then random items.
module counter_priority_task_scheduler_unit_test
  import cpts_pkg::*;
();

  typedef struct {
    logic [FUNC_W-1:0]    func;
    logic [SLOT_W-1:0]    slot;
    logic                 present;
    logic                 runnable;
    logic [IN_PRIO_W-1:0] prio;
    logic [CNT_W-1:0]     slice;
  } sched_item_t;

  typedef struct {
    status_t           status;
    logic [TASK_W-1:0] task_id;
    logic [CNT_W-1:0]  counter;
  } sched_result_t;

  // Shadow task table; predicts one result word per accepted item.
  class schedule_tracker;
    logic [PRIO_BITS-1:0] prio_tab [NUM_TASKS];
    logic [CNT_W-1:0]     cnt_tab [NUM_TASKS];
    logic                 present_tab [NUM_TASKS];
    logic                 runnable_tab [NUM_TASKS];
    int                   cur_slot;
    sched_result_t        pending_results [$];
    int                   errors;

    function new();
      for (int i = 0; i < NUM_TASKS; i++) begin
        prio_tab[i]     = '0;
        cnt_tab[i]      = '0;
        present_tab[i]  = 1'b0;
        runnable_tab[i] = 1'b0;
      end
      cur_slot = 0;
      errors   = 0;
    endfunction

    // Largest counter among present+runnable slots, ties to the highest slot; 0 = none.
    function int best_slot(output logic [CNT_W-1:0] best);
      int sel = 0;
      bit found = 1'b0;
      best = '0;
      for (int i = NUM_TASKS - 1; i >= 1; i--) begin
        if (present_tab[i] && runnable_tab[i] && (!found || cnt_tab[i] > best)) begin
          best  = cnt_tab[i];
          sel   = i;
          found = 1'b1;
        end
      end
      return sel;
    endfunction

    function void note_word(sched_item_t it);
      sched_result_t    r;
      int               c;
      int               sel;
      logic [CNT_W-1:0] best;
      logic [SUM_W-1:0] sum;
      c = cur_slot;
      if (it.func == FUNC_WRITE) begin
        if (it.slot >= 1 && it.slot < NUM_TASKS) begin
          present_tab[it.slot]  = it.present;
          runnable_tab[it.slot] = it.runnable;
          prio_tab[it.slot]     = it.prio[PRIO_BITS-1:0];
          cnt_tab[it.slot]      = it.slice;
        end
        r.status = ST_WRITTEN;
      end else if (c != 0 && cnt_tab[c] != 0) begin
        cnt_tab[c] = cnt_tab[c] - 1'b1;
        r.status   = ST_DOWN;
      end else begin
        sel = best_slot(best);
        if (sel == 0) begin
          r.status = ST_NONE;
        end else begin
          if (best == 0) begin
            for (int i = 1; i < NUM_TASKS; i++) begin
              if (present_tab[i]) begin
                sum = SUM_W'(cnt_tab[i] >> 1) + SUM_W'(prio_tab[i]);
                cnt_tab[i] = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[CNT_W-1:0];
              end
            end
            sel = best_slot(best);
          end
          if (best == 0 || sel == 0) begin
            r.status = ST_ZERO;
          end else begin
            if (sel == c) r.status = ST_KEPT;
            else r.status = ST_SWITCH;
            c = sel;
          end
        end
      end
      cur_slot  = c;
      r.task_id = c[TASK_W-1:0];
      r.counter = cnt_tab[c];
      pending_results.push_back(r);
    endfunction

    function void check_word(sched_result_t got);
      sched_result_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d task %0d counter %0d",
               got.status, got.task_id, got.counter);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.task_id !== want.task_id) begin
        $error("running_task: expected %0d, actual %0d", want.task_id, got.task_id);
        errors++;
      end
      if (got.counter !== want.counter) begin
        $error("running_counter: expected %0d, actual %0d", want.counter, got.counter);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT  = 600000;  // far above the slowest legal run
  localparam int RANDOM_WORDS = 1600;
  localparam int SETTLE       = 2 * NUM_TASKS + 8;  // refill pass worst case plus margin
  localparam int HOLD_CYCLES  = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cpts_in_if  in_ch ();
  cpts_out_if out_ch ();

  counter_priority_task_scheduler_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  schedule_tracker sched;

  int cycles = 0;
  bit calm = 1'b0;          // no idling on either side while set
  bit hold_request = 1'b0;  // asks the receiver for one long hold-off
  bit hold_done = 1'b0;

  always #5 clk = ~clk;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic sched_item_t make_item(logic [FUNC_W-1:0] func, int slot, bit p, bit r,
                                            int prio, int slice);
    sched_item_t it;
    it.func     = func;
    it.slot     = slot[SLOT_W-1:0];
    it.present  = p;
    it.runnable = r;
    it.prio     = prio[IN_PRIO_W-1:0];
    it.slice    = slice[CNT_W-1:0];
    return it;
  endfunction

  // Mostly ticks and small counters so picks and refills come often;
  // full-range values now and then so every field bit toggles.
  function automatic sched_item_t random_item();
    sched_item_t it;
    it.func     = ($urandom_range(99) < 60) ? FUNC_TICK : FUNC_WRITE;
    it.slot     = ($urandom_range(99) < 3) ? '0 : SLOT_W'($urandom_range(1, NUM_TASKS - 1));
    it.present  = ($urandom_range(99) < 80);
    it.runnable = ($urandom_range(99) < 75);
    it.prio     = ($urandom_range(99) < 20) ? IN_PRIO_W'($urandom_range(255))
                                            : IN_PRIO_W'($urandom_range(0, 6));
    it.slice    = ($urandom_range(99) < 15) ? CNT_W'($urandom_range(511))
                                            : CNT_W'($urandom_range(0, 4));
    return it;
  endfunction

  // Entered at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(sched_item_t it);
    if (!calm && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= it.func;
    in_ch.slot     <= it.slot;
    in_ch.present  <= it.present;
    in_ch.runnable <= it.runnable;
    in_ch.prio     <= it.prio;
    in_ch.slice    <= it.slice;
    do @(posedge clk); while (!in_ch.ready);
    sched.note_word(it);
    @(negedge clk);
  endtask

  // Hold valid low until every predicted word has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sched.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Result side: check at the rising edge, move ready at the falling edge.
  initial begin
    sched_result_t got;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        got.status  = status_t'(out_ch.status);
        got.task_id = out_ch.running_task;
        got.counter = out_ch.running_counter;
        sched.check_word(got);
      end
      @(negedge clk);
      if (hold_request && !hold_done) begin
        // long stall: output register holds its word, the next item waits at the check, input ready drops
        out_ch.ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  initial begin
    sched = new();
    in_ch.valid    = 1'b0;
    in_ch.func     = FUNC_TICK;
    in_ch.slot     = '0;
    in_ch.present  = 1'b0;
    in_ch.runnable = 1'b0;
    in_ch.prio     = '0;
    in_ch.slice    = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed part ---
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));         // empty table: no runnable
    send_word(make_item(FUNC_WRITE, 0, 1, 1, 255, 511));    // slot zero write dropped
    send_word(make_item(FUNC_TICK, 0, 1, 1, 255, 511));     // still nothing runnable
    send_word(make_item(FUNC_WRITE, 3, 1, 1, 0, 0));
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));         // refill leaves zero
    send_word(make_item(FUNC_WRITE, 3, 1, 1, 255, 0));
    send_word(make_item(FUNC_WRITE, 15, 0, 1, 200, 300));   // absent, not picked
    send_word(make_item(FUNC_WRITE, 9, 1, 0, 100, 50));     // present, not runnable
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));         // refill, switch to 3
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));         // count down
    send_word(make_item(FUNC_WRITE, 12, 1, 1, 128, 254));
    send_word(make_item(FUNC_WRITE, 3, 0, 1, 255, 2));      // current slot removed
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));         // removed task still counts
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));         // then a normal pick
    send_word(make_item(FUNC_WRITE, 12, 1, 1, 1, 0));
    send_word(make_item(FUNC_WRITE, 6, 1, 1, 1, 0));
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));         // tie after refill, kept
    send_word(make_item(FUNC_WRITE, 1, 1, 1, 255, 511));
    send_word(make_item(FUNC_WRITE, 2, 1, 1, 0, 511));
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));
    send_word(make_item(FUNC_TICK, 0, 0, 0, 0, 0));         // tie at max, higher slot
    send_word(make_item(FUNC_WRITE, 2, 0, 0, 0, 0));
    send_word(make_item(FUNC_WRITE, 1, 1, 0, 255, 0));

    // --- random part ---
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 500 && n < 800);
      if (n == 300) hold_request = 1'b1;
      if (n == 1000) drain();
      send_word(random_item());
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (sched.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sched.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
